>>> hw/rtl/f2i8_pkg.sv
// Package for the float to int8 quantizer: widths, types and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none
package f2i8_pkg;
	localparam int LANES = 8;
	localparam int FP_W = 32;
	localparam int CODE_W = 8;
	localparam int CNT_W = 4;
	localparam logic [FP_W-1:0] INV_SCALE_RESET = 32'h3F80_0000;
	localparam logic [7:0] EXP_BIAS = 8'd127;

	typedef logic [FP_W-1:0] fp_t;
	typedef logic signed [CODE_W-1:0] code_t;

	// Per-lane result of the multiply stage, before clamping and rounding.
	typedef struct packed {
		logic        nan;
		logic        sign;
		logic        zero;   // product rounds to zero or is zero
		logic        big;    // magnitude beyond any code (incl. infinity)
		logic [9:0]  exp;    // unbiased exponent, signed, valid when not big/zero
		logic [23:0] mant;   // normalised significand with hidden bit
	} prod_t;
endpackage
`default_nettype wire

>>> hw/rtl/f2i8_if.sv
// Valid/ready stream interfaces for the quantizer's input and result items.
// Depends on f2i8_pkg.
`default_nettype none
interface f2i8_in_if;
	logic valid;
	logic ready;
	f2i8_pkg::fp_t sample_0, sample_1, sample_2, sample_3;
	f2i8_pkg::fp_t sample_4, sample_5, sample_6, sample_7;
	logic [f2i8_pkg::CNT_W-1:0] lanes_valid;
	logic last_in;
	modport source(output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, sample_6, sample_7, lanes_valid, last_in, input ready);
	modport sink(input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
		sample_5, sample_6, sample_7, lanes_valid, last_in, output ready);
endinterface

interface f2i8_out_if;
	logic valid;
	logic ready;
	f2i8_pkg::code_t code_0, code_1, code_2, code_3, code_4, code_5, code_6, code_7;
	logic [f2i8_pkg::CNT_W-1:0] lanes_out;
	logic last_out;
	modport source(output valid, code_0, code_1, code_2, code_3, code_4, code_5,
		code_6, code_7, lanes_out, last_out, input ready);
	modport sink(input valid, code_0, code_1, code_2, code_3, code_4, code_5,
		code_6, code_7, lanes_out, last_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/f2i8_mul.sv
// One lane, first half: binary32 multiply with round to nearest even.
// Depends on f2i8_pkg; output is registered by the caller's pipeline.
`default_nettype none
module f2i8_mul (
	input  wire f2i8_pkg::fp_t  x,
	input  wire f2i8_pkg::fp_t  s,
	output f2i8_pkg::prod_t     p
);
	logic [7:0]  ex, es;
	logic [22:0] fx, fs;
	logic        x_nan, s_nan, x_inf, s_inf, x_z, s_z;
	logic [23:0] mx, ms;
	logic [47:0] prod;
	logic [23:0] m;
	logic        g, st, rnd;
	logic        hit;
	logic [24:0] mr;
	logic signed [10:0] e;
	logic signed [10:0] ef;
	logic [23:0] mfin;

	always_comb begin
		ex = x[30:23]; es = s[30:23];
		fx = x[22:0];  fs = s[22:0];
		x_nan = (ex == 8'hFF) && (fx != '0);
		s_nan = (es == 8'hFF) && (fs != '0);
		x_inf = (ex == 8'hFF) && (fx == '0);
		s_inf = (es == 8'hFF) && (fs == '0);
		x_z   = (ex == '0) && (fx == '0);
		s_z   = (es == '0) && (fs == '0);
		// Subnormals keep exponent 1 with no hidden bit. With one of them in
		// the product, its leading one can sit up to three places below bit 46
		// and still give a value of a quarter or more; anything lower is tiny.
		mx = {(ex != '0), fx};
		ms = {(es != '0), fs};
		prod = mx * ms;
		e = $signed({3'b0, (ex == '0) ? 8'd1 : ex}) + $signed({3'b0, (es == '0) ? 8'd1 : es})
			- 11'sd254;
		hit = 1'b1;
		if (prod[47]) begin
			m = prod[47:24]; g = prod[23]; st = |prod[22:0]; e = e + 11'sd1;
		end else if (prod[46]) begin
			m = prod[46:23]; g = prod[22]; st = |prod[21:0];
		end else if (prod[45]) begin
			m = prod[45:22]; g = prod[21]; st = |prod[20:0]; e = e - 11'sd1;
		end else if (prod[44]) begin
			m = prod[44:21]; g = prod[20]; st = |prod[19:0]; e = e - 11'sd2;
		end else if (prod[43]) begin
			m = prod[43:20]; g = prod[19]; st = |prod[18:0]; e = e - 11'sd3;
		end else begin
			m = prod[43:20]; g = 1'b0; st = 1'b0; hit = 1'b0;
		end
		rnd = g && (st || m[0]);
		mr = {1'b0, m} + {24'd0, rnd};
		if (mr[24]) begin
			mfin = mr[24:1]; ef = e + 11'sd1;
		end else begin
			mfin = mr[23:0]; ef = e;
		end
		p.nan  = x_nan || s_nan || (x_inf && s_z) || (s_inf && x_z);
		p.sign = x[31] ^ s[31];
		p.big  = x_inf || s_inf || (ef > 11'sd7);
		// Below 2^-2 the value rounds to zero after clamping anyway. An
		// infinite operand always clamps, however small the other one is.
		p.zero = !(x_inf || s_inf) && (x_z || s_z || !hit || (ef < -11'sd2));
		p.exp  = ef[9:0];
		p.mant = mfin;
	end
endmodule
`default_nettype wire

>>> hw/rtl/f2i8_rnd.sv
// One lane, second half: clamp to [-128,127] and round to integer, ties to even.
// Depends on f2i8_pkg.
`default_nettype none
module f2i8_rnd (
	input  wire f2i8_pkg::prod_t p,
	input  wire                  en,
	output f2i8_pkg::code_t      code
);
	logic [33:0] sh;
	logic [8:0]  ip;
	logic        g, st;
	logic [8:0]  mag;
	logic [3:0]  amt;

	always_comb begin
		// value = mant * 2^(exp-23); integer part = mant >> (23-exp), exp in -2..7
		amt = 4'(7 - $signed(p.exp));
		sh = {p.mant, 10'd0} >> amt;        // integer part lands in [33:26]
		ip = {1'b0, sh[33:26]};
		g  = sh[25];
		st = |sh[24:0];
		mag = ip + {8'd0, g && (st || ip[0])};
		code = '0;
		if (!en) begin
			code = '0;
		end else if (p.nan) begin
			code = -8'sd128;
		end else if (p.zero) begin
			code = '0;
		end else if (p.sign) begin
			code = (p.big || mag >= 9'd128) ? -8'sd128 : -$signed({1'b0, mag[6:0]});
		end else begin
			code = (p.big || mag >= 9'd127) ? 8'sd127 : $signed({1'b0, mag[6:0]});
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/float_to_int8_quantizer.sv
// Top level of the float to int8 quantizer: eight lanes, two register stages.
// Depends on f2i8_pkg, f2i8_if, f2i8_mul and f2i8_rnd.
//
//   Channel   Dir   Handshake        Carries
//   in        sink  valid/ready      sample_0..7, lanes_valid, last_in
//   out       src   valid/ready      code_0..7, lanes_out, last_out
//   cfg       in    cfg_we           cfg_data -> inv_scale
//
// Each item passes the multiply stage register, then the output register.
// One item is accepted per cycle while input ready is high.
// Reset clears both stage valid flags and loads inv_scale with 1.0.
// When the output stalls, stage one still drains into an empty output
// register; ready falls only when both stages are full and stalled.
`default_nettype none
module float_to_int8_quantizer (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       cfg_we,
	input  wire [31:0] cfg_data,
	f2i8_in_if.sink   in_ch,
	f2i8_out_if.source out_ch
);
	localparam int L = f2i8_pkg::LANES;

	f2i8_pkg::fp_t   inv_scale_q;
	f2i8_pkg::fp_t   smp [L];
	f2i8_pkg::prod_t prod [L];
	f2i8_pkg::prod_t prod_s1 [L];
	f2i8_pkg::code_t code [L];
	f2i8_pkg::code_t code_s2 [L];
	logic [f2i8_pkg::CNT_W-1:0] cnt_s1, cnt_s2;
	logic last_s1, last_s2;
	logic v_s1, v_s2;
	logic adv2, adv1;

	assign smp[0] = in_ch.sample_0; assign smp[1] = in_ch.sample_1;
	assign smp[2] = in_ch.sample_2; assign smp[3] = in_ch.sample_3;
	assign smp[4] = in_ch.sample_4; assign smp[5] = in_ch.sample_5;
	assign smp[6] = in_ch.sample_6; assign smp[7] = in_ch.sample_7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_scale_q <= f2i8_pkg::INV_SCALE_RESET;
		else if (cfg_we) inv_scale_q <= cfg_data;
	end

	// Stage two loads when empty or its item is taken; stage one moves when
	// stage two can load.
	assign adv2 = !v_s2 || out_ch.ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	for (genvar i = 0; i < L; i++) begin : g_lane
		f2i8_mul u_mul (.x(smp[i]), .s(inv_scale_q), .p(prod[i]));
		f2i8_rnd u_rnd (.p(prod_s1[i]), .en(cnt_s1 > 4'(i)), .code(code[i]));
		always_ff @(posedge clk) begin
			if (adv1) prod_s1[i] <= prod[i];
			if (adv2) code_s2[i] <= code[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			cnt_s1 <= in_ch.lanes_valid; last_s1 <= in_ch.last_in;
		end
		if (adv2) begin
			cnt_s2 <= cnt_s1; last_s2 <= last_s1;
		end
	end

	assign out_ch.valid = v_s2;
	assign out_ch.code_0 = code_s2[0]; assign out_ch.code_1 = code_s2[1];
	assign out_ch.code_2 = code_s2[2]; assign out_ch.code_3 = code_s2[3];
	assign out_ch.code_4 = code_s2[4]; assign out_ch.code_5 = code_s2[5];
	assign out_ch.code_6 = code_s2[6]; assign out_ch.code_7 = code_s2[7];
	assign out_ch.lanes_out = cnt_s2;
	assign out_ch.last_out = last_s2;

	// A full output stage that is stalled keeps its item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ch.ready |=> v_s2 && $stable(cnt_s2)) else $error("output item lost");
	// Ready only drops when both stages hold items.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> v_s1 && v_s2) else $error("needless back-pressure");
	// An accepted item reaches stage one.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1) else $error("item dropped");
endmodule
`default_nettype wire

>>> verif/f2i8_checker.sv
// Scoreboard for the float to int8 quantizer: watches both streams and the
// register port, predicts every result item and compares it field by field.
// Depends on f2i8_pkg and f2i8_if.
`timescale 1ns / 1ps
module f2i8_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [31:0] cfg_data,
	f2i8_in_if         in_ch,
	f2i8_out_if        out_ch,
	output int         failures,
	output int         pending
);
	typedef struct {
		f2i8_pkg::code_t code [f2i8_pkg::LANES];
		logic [3:0]      lanes;
		logic            last;
	} quant_result_t;

	quant_result_t expected_codes [$];
	f2i8_pkg::fp_t scale_shadow;

	// Binary32 multiply, round to nearest even, subnormals kept.
	function automatic f2i8_pkg::fp_t fp_mul(f2i8_pkg::fp_t a, f2i8_pkg::fp_t b);
		logic        s;
		logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
		logic [23:0] ma, mb;
		logic [47:0] mp;
		logic [63:0] sig, rem, half;
		int          ea, eb, lead, be, shift;
		longint      total;
		s = a[31] ^ b[31];
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
			return 32'h7FC0_0000;
		if (a_inf || b_inf)
			return {s, 31'h7F80_0000};
		if (a_zero || b_zero)
			return {s, 31'h0};
		ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
		ma = {a[30:23] != 8'd0, a[22:0]};
		mb = {b[30:23] != 8'd0, b[22:0]};
		mp = {24'd0, ma} * {24'd0, mb};
		lead = 0;
		for (int i = 0; i < 48; i++)
			if (mp[i])
				lead = i;
		be = lead + ea + eb - 173;
		shift = lead - 23;
		// Below the normal range the significand is shifted further right
		// and the exponent field is pinned; a carry out then lands in the
		// smallest normal exponent by itself.
		if (be < 1) begin
			shift += 1 - be;
			be = 1;
		end
		if (shift <= 0) begin
			sig = {16'd0, mp} << (-shift);
		end else if (shift > 60) begin
			sig = 64'd0;
		end else begin
			sig = {16'd0, mp} >> shift;
			rem = {16'd0, mp} & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			if (rem > half || (rem == half && sig[0]))
				sig = sig + 64'd1;
		end
		total = longint'(be - 1) * 64'h80_0000 + longint'(sig);
		if (total >= 64'h7F80_0000)
			return {s, 31'h7F80_0000};
		return {s, total[30:0]};
	endfunction

	// Clamp to the code range, NaN to the bottom, then round ties to even.
	function automatic f2i8_pkg::code_t clamp_round(f2i8_pkg::fp_t p);
		logic [30:0] mag;
		logic [23:0] sig24, ip, rem, half;
		int          e, sh;
		mag = p[30:0];
		if (mag > 31'h7F80_0000)
			return -8'sd128;
		if (p[31] && mag >= 31'h4300_0000)
			return -8'sd128;
		if (!p[31] && mag >= 31'h42FE_0000)
			return 8'sd127;
		e = int'(p[30:23]) - 127;
		if (e < -1)
			return 8'sd0;
		sh = 23 - e;
		sig24 = {1'b1, p[22:0]};
		ip = sig24 >> sh;
		rem = sig24 & ((24'd1 << sh) - 24'd1);
		half = 24'd1 << (sh - 1);
		if (rem > half || (rem == half && ip[0]))
			ip = ip + 24'd1;
		return p[31] ? f2i8_pkg::code_t'(-ip[7:0]) : f2i8_pkg::code_t'(ip[7:0]);
	endfunction

	function automatic quant_result_t quantize_item(f2i8_pkg::fp_t smp [f2i8_pkg::LANES],
			logic [3:0] count, logic last, f2i8_pkg::fp_t scale);
		quant_result_t r;
		int            n;
		n = (count > f2i8_pkg::LANES) ? f2i8_pkg::LANES : int'(count);
		for (int j = 0; j < f2i8_pkg::LANES; j++)
			r.code[j] = (j < n) ? clamp_round(fp_mul(smp[j], scale)) : 8'sd0;
		r.lanes = count;
		r.last = last;
		return r;
	endfunction

	assign pending = expected_codes.size();

	always @(posedge clk or negedge arst_n) begin
		f2i8_pkg::fp_t   smp [f2i8_pkg::LANES];
		f2i8_pkg::code_t got [f2i8_pkg::LANES];
		quant_result_t   exp_r;
		int              miss;
		miss = 0;
		if (!arst_n) begin
			scale_shadow <= f2i8_pkg::INV_SCALE_RESET;
			failures <= 0;
			expected_codes.delete();
		end else begin
			if (cfg_we)
				scale_shadow <= cfg_data;
			if (in_ch.valid && in_ch.ready) begin
				smp = '{in_ch.sample_0, in_ch.sample_1, in_ch.sample_2, in_ch.sample_3,
					in_ch.sample_4, in_ch.sample_5, in_ch.sample_6, in_ch.sample_7};
				expected_codes.push_back(quantize_item(smp, in_ch.lanes_valid,
					in_ch.last_in, scale_shadow));
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_codes.size() == 0) begin
					$error("result item with no expectation waiting");
					miss = miss + 1;
				end else begin
					exp_r = expected_codes.pop_front();
					got = '{out_ch.code_0, out_ch.code_1, out_ch.code_2, out_ch.code_3,
						out_ch.code_4, out_ch.code_5, out_ch.code_6, out_ch.code_7};
					for (int j = 0; j < f2i8_pkg::LANES; j++)
						if (got[j] !== exp_r.code[j]) begin
							$error("code_%0d: expected %0d, got %0d", j, exp_r.code[j], got[j]);
							miss = miss + 1;
						end
					if (out_ch.lanes_out !== exp_r.lanes) begin
						$error("lanes_out: expected %0d, got %0d", exp_r.lanes, out_ch.lanes_out);
						miss = miss + 1;
					end
					if (out_ch.last_out !== exp_r.last) begin
						$error("last_out: expected %0b, got %0b", exp_r.last, out_ch.last_out);
						miss = miss + 1;
					end
				end
			end
			failures <= failures + miss;
		end
	end
endmodule

>>> verif/tb_float_to_int8_quantizer.sv
// Top of the quantizer testbench: clock, reset, stimulus, register writes
// and the verdict. Depends on f2i8_pkg, f2i8_if, f2i8_checker and the block.
`timescale 1ns / 1ps
module tb_float_to_int8_quantizer;
	localparam int MAX_GAP = 12;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_OFF = 80;
	localparam int RANDOM_PER_SCALE = 30;
	localparam int DRAIN_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_data = 32'd0;
	int          failures;
	int          pending;
	int          accepted_items = 0;
	int          idle_cycles = 0;

	f2i8_in_if  in_ch ();
	f2i8_out_if out_ch ();

	float_to_int8_quantizer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	f2i8_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.failures(failures),
		.pending (pending)
	);

	always #5 clk = ~clk;

	// Every block input starts at a known value before the first edge.
	initial begin
		in_ch.valid = 1'b0;
		in_ch.sample_0 = '0; in_ch.sample_1 = '0; in_ch.sample_2 = '0; in_ch.sample_3 = '0;
		in_ch.sample_4 = '0; in_ch.sample_5 = '0; in_ch.sample_6 = '0; in_ch.sample_7 = '0;
		in_ch.lanes_valid = '0;
		in_ch.last_in = 1'b0;
		out_ch.ready = 1'b0;
	end

	// Watchdog: a run of cycles in which no item moves on either channel
	// means the block has locked up.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (in_ch.valid && in_ch.ready)
			accepted_items <= accepted_items + 1;

	// Result side. All outputs of the block settle after the rising edge, so
	// ready and valid are read at the falling edge and the handshake counts
	// at the next rising edge. Once, part way through, the receiver holds
	// off for a long stretch so that both stages fill and input ready falls.
	initial begin
		int  gap;
		bit  hs;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_items > 150) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				hs = out_ch.valid;
				if (!hs)
					@(posedge clk);
			end while (!hs);
		end
	end

	function automatic f2i8_pkg::fp_t odd_half(int k);
		int n, msb;
		logic [31:0] u;
		// (2k+1)/2 is always an exact tie between two integers.
		n = 2 * k + 1;
		msb = $clog2(n + 1) - 1;
		u = n;
		return {1'b0, 8'(msb - 1 + 127), 23'((u << (23 - msb)) & 32'h7F_FFFF)};
	endfunction

	// Mostly values whose product lands inside the code range, with ties,
	// specials, tiny values and raw bit patterns mixed in.
	function automatic f2i8_pkg::fp_t random_sample();
		f2i8_pkg::fp_t specials [8] = '{32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h42FF_0000};
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			7:       return odd_half($urandom_range(0, 130)) | {1'($urandom), 31'd0};
			8:       return specials[$urandom_range(0, 7)];
			9:       return {1'($urandom), 8'($urandom_range(0, 125)), 23'($urandom)};
			default: return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
		endcase
	endfunction

	task automatic send_item(f2i8_pkg::fp_t s [f2i8_pkg::LANES], logic [3:0] lanes,
			logic last);
		int gap;
		bit hs;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_0 <= s[0]; in_ch.sample_1 <= s[1];
		in_ch.sample_2 <= s[2]; in_ch.sample_3 <= s[3];
		in_ch.sample_4 <= s[4]; in_ch.sample_5 <= s[5];
		in_ch.sample_6 <= s[6]; in_ch.sample_7 <= s[7];
		in_ch.lanes_valid <= lanes;
		in_ch.last_in <= last;
		do begin
			@(negedge clk);
			hs = in_ch.ready;
			@(posedge clk);
		end while (!hs);
	endtask

	task automatic send_random();
		f2i8_pkg::fp_t s [f2i8_pkg::LANES];
		logic [3:0] lanes;
		for (int j = 0; j < f2i8_pkg::LANES; j++)
			s[j] = random_sample();
		// Full vectors dominate; short tails and out-of-range counts follow.
		case ($urandom_range(0, 7))
			0:       lanes = 4'($urandom_range(1, 7));
			1:       lanes = 4'($urandom);
			default: lanes = 4'd8;
		endcase
		send_item(s, lanes, ($urandom_range(0, 5) == 0));
	endtask

	// A register write happens only with the pipeline empty.
	task automatic write_inv_scale(logic [31:0] value);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		f2i8_pkg::fp_t s [f2i8_pkg::LANES];
		logic [31:0] scales [12];
		scales = '{32'h0000_0000, 32'h7F80_0000, 32'h7FC0_0000,
			32'h0000_0001, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h3C00_0000, 32'h42FE_0000,
			32'h3F00_0000, 32'h3F80_0000, 32'h0, 32'h0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset scale of one: ties on both sides of
		// zero, the clamp edges, NaN, infinities, signed zero, subnormals.
		s = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'h3FC0_0000,
			32'h4020_0000, 32'hBF00_0000, 32'hC020_0000, 32'h42FD_0000};
		send_item(s, 4'd8, 1'b0);
		s = '{32'h42FF_0000, 32'hC301_0000, 32'hC2FF_0000, 32'h7FC0_0000,
			32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF, 32'h0000_0001};
		send_item(s, 4'd8, 1'b1);
		s = '{32'hFFFF_FFFF, 32'hFF7F_FFFF, 32'h3EFF_FFFF, 32'hBEFF_FFFF,
			32'h3F3F_FFFF, 32'h42FE_FFFF, 32'hC300_0000, 32'h8000_0001};
		send_item(s, 4'd8, 1'b0);
		send_item(s, 4'd0, 1'b1);
		send_item(s, 4'd1, 1'b0);
		send_item(s, 4'd7, 1'b1);
		send_item(s, 4'd9, 1'b0);
		send_item(s, 4'd15, 1'b1);
		for (int k = 0; k < 8; k++) begin
			for (int j = 0; j < f2i8_pkg::LANES; j++)
				s[j] = odd_half(16 * k + 2 * j) | {1'(j[0]), 31'd0};
			send_item(s, 4'd8, 1'(k[0]));
		end
		for (int i = 0; i < RANDOM_PER_SCALE; i++)
			send_random();

		// Each scale gets its own phase; the last two are random patterns,
		// one unconstrained and one of moderate size.
		scales[10] = $urandom;
		scales[11] = {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
		foreach (scales[p]) begin
			write_inv_scale(scales[p]);
			for (int i = 0; i < RANDOM_PER_SCALE; i++)
				send_random();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
